@@ sv/tla_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths and carried-data types for the two-link apex solver.
package tla_pkg;

    localparam int CW    = 24;              // coordinate width
    localparam int LW    = CW - 1;          // side length width
    localparam int AW    = CW + 1;          // coordinate difference magnitude
    localparam int DFW   = 2 * AW;          // squared distance, full range
    localparam int HW    = 2 * CW;          // squared distance inside a triangle
    localparam int KW    = 4 * CW;          // radicand
    localparam int RW    = 2 * CW;          // root
    localparam int RHW   = RW / 2;
    localparam int NW    = 2 * CW + 2;      // |N|
    localparam int NHW   = NW / 2;
    localparam int PW    = NW + AW;         // product magnitude
    localparam int QW    = CW;              // quotient
    localparam int DVSW  = 2 * CW + 1;      // divisor 2D
    localparam int DVDW  = QW + DVSW;       // dividend
    localparam int FRONT = 7;               // register stages before the root
    localparam int MIDST = 5;               // register stages between root and divide
    localparam int LAT   = FRONT + RW + MIDST + QW + 1;

    typedef struct packed {
        logic                 ok;
        logic                 ccw;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 dxn;
        logic                 dyn;
        logic [AW-1:0]        adx;
        logic [AW-1:0]        ady;
        logic                 nneg;
        logic [NW-1:0]        nmag;
        logic [HW-1:0]        d;
    } t_front;

    typedef struct packed {
        logic                 ok;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic                 xneg;
        logic                 yneg;
    } t_back;

endpackage

@@ sv/tla_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, two radicand bits per stage.
module tla_sqrt import tla_pkg::*; (
    input  logic          i_clk,
    input  logic [KW-1:0] i_rad,
    output logic [RW-1:0] o_root
);
    localparam int RMW = RW + 2;

    logic [KW-1:0]  r_rad  [RW];
    logic [RMW-1:0] r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic [KW-1:0]  n_rad  [RW];
    logic [RMW-1:0] n_rem  [RW];
    logic [RW-1:0]  n_root [RW];
    logic [KW-1:0]  w_rad_in  [RW];
    logic [RMW-1:0] w_rem_in  [RW];
    logic [RW-1:0]  w_root_in [RW];

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_in
            if (g == 0) begin : g_first
                assign w_rad_in[g]  = i_rad;
                assign w_rem_in[g]  = '0;
                assign w_root_in[g] = '0;
            end else begin : g_rest
                assign w_rad_in[g]  = r_rad[g-1];
                assign w_rem_in[g]  = r_rem[g-1];
                assign w_root_in[g] = r_root[g-1];
            end
        end
    endgenerate

    always_comb begin
        logic [RMW-1:0] sh;
        logic [RMW-1:0] trial;
        for (int k = 0; k < RW; k++) begin
            sh       = {w_rem_in[k][RMW-3:0], w_rad_in[k][KW-1:KW-2]};
            trial    = {w_root_in[k], 2'b01};
            n_rad[k] = {w_rad_in[k][KW-3:0], 2'b00};
            if (sh >= trial) begin
                n_rem[k]  = sh - trial;
                n_root[k] = {w_root_in[k][RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = sh;
                n_root[k] = {w_root_in[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RW; k++) begin
            r_rad[k]  <= n_rad[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[RW-1];

endmodule

@@ sv/tla_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module tla_div import tla_pkg::*; (
    input  logic            i_clk,
    input  logic [DVDW-1:0] i_dvd,
    input  logic [DVSW-1:0] i_dvs,
    output logic [QW-1:0]   o_quo
);
    // quotient is known to fit QW bits, so the high dividend part starts below the divisor
    logic [DVSW-1:0] r_rem [QW];
    logic [QW-1:0]   r_lq  [QW];
    logic [DVSW-1:0] r_dvs [QW];
    logic [DVSW-1:0] n_rem [QW];
    logic [QW-1:0]   n_lq  [QW];
    logic [DVSW-1:0] w_rem_in [QW];
    logic [QW-1:0]   w_lq_in  [QW];
    logic [DVSW-1:0] w_dvs_in [QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_in
            if (g == 0) begin : g_first
                assign w_rem_in[g] = i_dvd[DVDW-1:QW];
                assign w_lq_in[g]  = i_dvd[QW-1:0];
                assign w_dvs_in[g] = i_dvs;
            end else begin : g_rest
                assign w_rem_in[g] = r_rem[g-1];
                assign w_lq_in[g]  = r_lq[g-1];
                assign w_dvs_in[g] = r_dvs[g-1];
            end
        end
    endgenerate

    always_comb begin
        logic [DVSW:0] sh;
        logic [DVSW:0] diff;
        for (int k = 0; k < QW; k++) begin
            sh   = {w_rem_in[k], w_lq_in[k][QW-1]};
            diff = sh - {1'b0, w_dvs_in[k]};
            if (sh >= {1'b0, w_dvs_in[k]}) begin
                n_rem[k] = diff[DVSW-1:0];
                n_lq[k]  = {w_lq_in[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[DVSW-1:0];
                n_lq[k]  = {w_lq_in[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_rem[k] <= n_rem[k];
            r_lq[k]  <= n_lq[k];
            r_dvs[k] <= w_dvs_in[k];
        end
    end

    assign o_quo = r_lq[QW-1];

endmodule

@@ sv/two_link_apex_solver.sv @@
`timescale 1ns / 1ps
// Two-link planar joint solver: fully pipelined, one item per clock.
// Stages that an item passes from the accepting edge to the edge that takes the result
// (7 front stages, 48 root stages, 5 product stages, 24 divide stages, 1 output stage).
// Throughput: one item every cycle; busy is always low, results cannot be held off.
// The root and divide pipelines set the depth. Reset clears only the valid bits.
module two_link_apex_solver import tla_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [CW-1:0] i_a_x,
    input  logic signed [CW-1:0] i_a_y,
    input  logic signed [CW-1:0] i_b_x,
    input  logic signed [CW-1:0] i_b_y,
    input  logic [LW-1:0]        i_side_ac,
    input  logic [LW-1:0]        i_side_bc,
    input  logic                 i_bend_ccw,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_joint_x,
    output logic signed [CW-1:0] o_joint_y,
    output logic                 o_solvable
);
    localparam logic signed [CW+1:0] CMAX = (CW+2)'((2 ** (CW-1)) - 1);
    localparam logic signed [CW+1:0] CMIN = -(CW+2)'(2 ** (CW-1));

    assign busy = 1'b0;

    logic [FRONT-1:0] r_fv;     // front stage valid bits
    logic [RW-1:0]    r_sv;     // root stage valid bits
    logic [MIDST-1:0] r_pv;     // product stage valid bits
    logic [QW-1:0]    r_dv;     // divide stage valid bits

    // stage 1
    logic signed [CW-1:0] r1_ax, r1_ay;
    logic signed [AW-1:0] r1_dx, r1_dy;
    logic [LW-1:0]        r1_r1, r1_r2;
    logic                 r1_ccw;
    // stage 2
    logic signed [CW-1:0] r2_ax, r2_ay;
    logic [AW-1:0]        r2_adx, r2_ady;
    logic                 r2_dxn, r2_dyn, r2_ccw;
    logic [LW-1:0]        r2_r1, r2_r2, r2_diff;
    logic [CW-1:0]        r2_sum;
    // stage 3
    logic signed [CW-1:0] r3_ax, r3_ay;
    logic [AW-1:0]        r3_adx, r3_ady;
    logic                 r3_dxn, r3_dyn, r3_ccw;
    logic [2*AW-1:0]      r3_dx2, r3_dy2;
    logic [2*CW-1:0]      r3_sum2;
    logic [2*LW-1:0]      r3_diff2, r3_r1sq, r3_r2sq;
    // stage 4
    logic signed [CW-1:0]   r4_ax, r4_ay;
    logic [AW-1:0]          r4_adx, r4_ady;
    logic                   r4_dxn, r4_dyn, r4_ccw;
    logic [DFW-1:0]         r4_d;
    logic signed [2*LW:0]   r4_t;
    logic [2*CW-1:0]        r4_sum2;
    logic [2*LW-1:0]        r4_diff2;
    // stage 5
    logic signed [CW-1:0]   r5_ax, r5_ay;
    logic [AW-1:0]          r5_adx, r5_ady;
    logic                   r5_dxn, r5_dyn, r5_ccw, r5_ok;
    logic [HW-1:0]          r5_d, r5_a, r5_b;
    logic signed [NW:0]     r5_n;
    // stage 6
    t_front                 r6_f;
    logic [2*CW-1:0]        r6_p00, r6_p01, r6_p10, r6_p11;
    // stage 7
    t_front                 r7_f;
    logic [KW-1:0]          r7_k;

    t_front                 r_sd [RW];
    logic [RW-1:0]          w_root;

    // product stages
    t_front                 r_p1_f, r_p2_f, r_p3_f, r_p4_f;
    logic [2*AW-1:0]        r_p1_nxl, r_p1_nxh, r_p1_nyl, r_p1_nyh;
    logic [RHW+AW-1:0]      r_p1_syl, r_p1_syh, r_p1_sxl, r_p1_sxh;
    logic [PW-1:0]          r_p2_nx, r_p2_ny, r_p2_sy, r_p2_sx;
    logic signed [PW+1:0]   r_p3_x, r_p3_y;
    logic [PW+1:0]          r_p4_xm, r_p4_ym;
    logic                   r_p4_xn, r_p4_yn;
    t_back                  r_p5_b;
    logic [DVDW-1:0]        r_p5_dx, r_p5_dy;
    logic [DVSW-1:0]        r_p5_dvs;

    t_back                  r_dd [QW];
    logic [QW-1:0]          w_qx, w_qy;

    logic signed [CW+1:0]   n_cx, n_cy;
    logic signed [CW-1:0]   n_jx, n_jy;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv    <= '0;
            r_sv    <= '0;
            r_pv    <= '0;
            r_dv    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_fv    <= {r_fv[FRONT-2:0], start & ~busy};
            r_sv    <= {r_sv[RW-2:0], r_fv[FRONT-1]};
            r_pv    <= {r_pv[MIDST-2:0], r_sv[RW-1]};
            r_dv    <= {r_dv[QW-2:0], r_pv[MIDST-1]};
            o_valid <= r_dv[QW-1];
        end
    end

    // front stages: squares, triangle test, N and K
    always_ff @(posedge i_clk) begin
        r1_ax  <= i_a_x;
        r1_ay  <= i_a_y;
        r1_dx  <= $signed({i_b_x[CW-1], i_b_x}) - $signed({i_a_x[CW-1], i_a_x});
        r1_dy  <= $signed({i_b_y[CW-1], i_b_y}) - $signed({i_a_y[CW-1], i_a_y});
        r1_r1  <= i_side_ac;
        r1_r2  <= i_side_bc;
        r1_ccw <= i_bend_ccw;

        r2_ax   <= r1_ax;
        r2_ay   <= r1_ay;
        r2_dxn  <= r1_dx[AW-1];
        r2_dyn  <= r1_dy[AW-1];
        r2_adx  <= r1_dx[AW-1] ? AW'(-r1_dx) : AW'(r1_dx);
        r2_ady  <= r1_dy[AW-1] ? AW'(-r1_dy) : AW'(r1_dy);
        r2_ccw  <= r1_ccw;
        r2_r1   <= r1_r1;
        r2_r2   <= r1_r2;
        r2_sum  <= {1'b0, r1_r1} + {1'b0, r1_r2};
        r2_diff <= (r1_r1 > r1_r2) ? r1_r1 - r1_r2 : r1_r2 - r1_r1;

        r3_ax    <= r2_ax;
        r3_ay    <= r2_ay;
        r3_adx   <= r2_adx;
        r3_ady   <= r2_ady;
        r3_dxn   <= r2_dxn;
        r3_dyn   <= r2_dyn;
        r3_ccw   <= r2_ccw;
        r3_dx2   <= r2_adx * r2_adx;
        r3_dy2   <= r2_ady * r2_ady;
        r3_sum2  <= r2_sum * r2_sum;
        r3_diff2 <= r2_diff * r2_diff;
        r3_r1sq  <= r2_r1 * r2_r1;
        r3_r2sq  <= r2_r2 * r2_r2;

        r4_ax    <= r3_ax;
        r4_ay    <= r3_ay;
        r4_adx   <= r3_adx;
        r4_ady   <= r3_ady;
        r4_dxn   <= r3_dxn;
        r4_dyn   <= r3_dyn;
        r4_ccw   <= r3_ccw;
        r4_d     <= DFW'(r3_dx2) + DFW'(r3_dy2);
        r4_t     <= $signed({1'b0, r3_r1sq}) - $signed({1'b0, r3_r2sq});
        r4_sum2  <= r3_sum2;
        r4_diff2 <= r3_diff2;

        r5_ax  <= r4_ax;
        r5_ay  <= r4_ay;
        r5_adx <= r4_adx;
        r5_ady <= r4_ady;
        r5_dxn <= r4_dxn;
        r5_dyn <= r4_dyn;
        r5_ccw <= r4_ccw;
        r5_ok  <= (r4_d > DFW'(r4_diff2)) && (r4_d < DFW'(r4_sum2));
        r5_d   <= r4_d[HW-1:0];
        r5_a   <= r4_sum2 - r4_d[HW-1:0];
        r5_b   <= r4_d[HW-1:0] - HW'(r4_diff2);
        r5_n   <= $signed({1'b0, r4_d[HW-1:0]}) + (NW+1)'(r4_t);

        r6_f.ok   <= r5_ok;
        r6_f.ccw  <= r5_ccw;
        r6_f.ax   <= r5_ax;
        r6_f.ay   <= r5_ay;
        r6_f.dxn  <= r5_dxn;
        r6_f.dyn  <= r5_dyn;
        r6_f.adx  <= r5_adx;
        r6_f.ady  <= r5_ady;
        r6_f.nneg <= r5_n[NW];
        r6_f.nmag <= r5_n[NW] ? NW'(-r5_n) : NW'(r5_n);
        r6_f.d    <= r5_d;
        r6_p00    <= r5_a[CW-1:0]    * r5_b[CW-1:0];
        r6_p01    <= r5_a[CW-1:0]    * r5_b[HW-1:CW];
        r6_p10    <= r5_a[HW-1:CW]   * r5_b[CW-1:0];
        r6_p11    <= r5_a[HW-1:CW]   * r5_b[HW-1:CW];

        r7_f <= r6_f;
        r7_k <= KW'(r6_p00) + (KW'(r6_p01) << CW) + (KW'(r6_p10) << CW)
              + (KW'(r6_p11) << (2*CW));
    end

    tla_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r7_k),
        .o_root (w_root)
    );

    // side data rides alongside the root pipeline
    always_ff @(posedge i_clk) begin
        r_sd[0] <= r7_f;
        for (int k = 1; k < RW; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // products, signed sums, magnitudes, rounding offset
    always_ff @(posedge i_clk) begin
        r_p1_f    <= r_sd[RW-1];
        r_p1_nxl  <= AW'(r_sd[RW-1].nmag[NHW-1:0])  * r_sd[RW-1].adx;
        r_p1_nxh  <= AW'(r_sd[RW-1].nmag[NW-1:NHW]) * r_sd[RW-1].adx;
        r_p1_nyl  <= AW'(r_sd[RW-1].nmag[NHW-1:0])  * r_sd[RW-1].ady;
        r_p1_nyh  <= AW'(r_sd[RW-1].nmag[NW-1:NHW]) * r_sd[RW-1].ady;
        r_p1_syl  <= w_root[RHW-1:0]  * r_sd[RW-1].ady;
        r_p1_syh  <= w_root[RW-1:RHW] * r_sd[RW-1].ady;
        r_p1_sxl  <= w_root[RHW-1:0]  * r_sd[RW-1].adx;
        r_p1_sxh  <= w_root[RW-1:RHW] * r_sd[RW-1].adx;

        r_p2_f  <= r_p1_f;
        r_p2_nx <= PW'(r_p1_nxl) + (PW'(r_p1_nxh) << NHW);
        r_p2_ny <= PW'(r_p1_nyl) + (PW'(r_p1_nyh) << NHW);
        r_p2_sy <= PW'(r_p1_syl) + (PW'(r_p1_syh) << RHW);
        r_p2_sx <= PW'(r_p1_sxl) + (PW'(r_p1_sxh) << RHW);

        // x = N dx - s S dy, y = s S dx + N dy, s = +1 for counter-clockwise
        r_p3_f <= r_p2_f;
        r_p3_x <= ((r_p2_f.nneg ^ r_p2_f.dxn) ? -$signed({2'b00, r_p2_nx})
                                               :  $signed({2'b00, r_p2_nx}))
                + ((r_p2_f.ccw ^ r_p2_f.dyn)  ? -$signed({2'b00, r_p2_sy})
                                               :  $signed({2'b00, r_p2_sy}));
        r_p3_y <= ((~r_p2_f.ccw ^ r_p2_f.dxn) ? -$signed({2'b00, r_p2_sx})
                                               :  $signed({2'b00, r_p2_sx}))
                + ((r_p2_f.nneg ^ r_p2_f.dyn) ? -$signed({2'b00, r_p2_ny})
                                               :  $signed({2'b00, r_p2_ny}));

        r_p4_f  <= r_p3_f;
        r_p4_xn <= r_p3_x[PW+1];
        r_p4_yn <= r_p3_y[PW+1];
        r_p4_xm <= r_p3_x[PW+1] ? (PW+2)'(-r_p3_x) : (PW+2)'(r_p3_x);
        r_p4_ym <= r_p3_y[PW+1] ? (PW+2)'(-r_p3_y) : (PW+2)'(r_p3_y);

        // round to nearest: floor((|num| + D) / 2D)
        r_p5_b.ok   <= r_p4_f.ok;
        r_p5_b.ax   <= r_p4_f.ax;
        r_p5_b.ay   <= r_p4_f.ay;
        r_p5_b.xneg <= r_p4_xn;
        r_p5_b.yneg <= r_p4_yn;
        r_p5_dx     <= r_p4_xm[DVDW-1:0] + DVDW'(r_p4_f.d);
        r_p5_dy     <= r_p4_ym[DVDW-1:0] + DVDW'(r_p4_f.d);
        r_p5_dvs    <= {r_p4_f.d, 1'b0};
    end

    tla_div u_div_x (
        .i_clk (i_clk),
        .i_dvd (r_p5_dx),
        .i_dvs (r_p5_dvs),
        .o_quo (w_qx)
    );

    tla_div u_div_y (
        .i_clk (i_clk),
        .i_dvd (r_p5_dy),
        .i_dvs (r_p5_dvs),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        r_dd[0] <= r_p5_b;
        for (int k = 1; k < QW; k++) begin
            r_dd[k] <= r_dd[k-1];
        end
    end

    // final offset from a, saturated; zero when the item is not solvable
    always_comb begin
        n_cx = r_dd[QW-1].xneg
             ? $signed({{2{r_dd[QW-1].ax[CW-1]}}, r_dd[QW-1].ax}) - $signed({2'b00, w_qx})
             : $signed({{2{r_dd[QW-1].ax[CW-1]}}, r_dd[QW-1].ax}) + $signed({2'b00, w_qx});
        n_cy = r_dd[QW-1].yneg
             ? $signed({{2{r_dd[QW-1].ay[CW-1]}}, r_dd[QW-1].ay}) - $signed({2'b00, w_qy})
             : $signed({{2{r_dd[QW-1].ay[CW-1]}}, r_dd[QW-1].ay}) + $signed({2'b00, w_qy});
        if (!r_dd[QW-1].ok) begin
            n_jx = '0;
        end else if (n_cx > CMAX) begin
            n_jx = CW'(CMAX);
        end else if (n_cx < CMIN) begin
            n_jx = CW'(CMIN);
        end else begin
            n_jx = CW'(n_cx);
        end
        if (!r_dd[QW-1].ok) begin
            n_jy = '0;
        end else if (n_cy > CMAX) begin
            n_jy = CW'(CMAX);
        end else if (n_cy < CMIN) begin
            n_jy = CW'(CMIN);
        end else begin
            n_jy = CW'(n_cy);
        end
    end

    always_ff @(posedge i_clk) begin
        o_joint_x  <= n_jx;
        o_joint_y  <= n_jy;
        o_solvable <= r_dd[QW-1].ok;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("item did not come out after the pipeline latency");

    a_zero_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_side_ac == '0) |-> ##LAT !o_solvable)
        else $error("zero-length side reported as solvable");

    a_same_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_a_x == i_b_x && i_a_y == i_b_y) |-> ##LAT !o_solvable)
        else $error("coincident ends reported as solvable");

    a_zero_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_solvable) |-> (o_joint_x == '0 && o_joint_y == '0))
        else $error("unsolvable item carries a nonzero joint");

endmodule
